// ===== rtl/rcsp_pkg.sv =====
// Package of shared types and constants for the request stream parser.
`default_nettype none

package rcsp_pkg;

  localparam int unsigned MAX_PARTS_DEF       = 16;
  localparam int unsigned MAX_PART_LENGTH_DEF = 65535;
  localparam int unsigned QUEUE_DEPTH         = 4;

  localparam logic [7:0] CHR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHR_MINUS   = 8'h2d;
  localparam logic [7:0] CHR_PLUS    = 8'h2b;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_LOW_A   = 8'h61;
  localparam logic [7:0] CHR_LOW_Z   = 8'h7a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [1:0] TRAILER_LEN = 2'd2;

  typedef enum logic [2:0] {
    ST_DATA       = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_BAD_MARKER = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_TOO_MANY   = 3'd4
  } status_t;

  // One classified result on its way from the parser to the output stage.
  typedef struct packed {
    status_t    status;
    logic [7:0] data;
    logic [3:0] part;
    logic       part_end;
    logic       command_end;
    logic       fold;
  } rcsp_rec_t;

endpackage

`default_nettype wire

// ===== rtl/rcsp_if.sv =====
// Stream interfaces for request bytes in and parsed results out.
`default_nettype none

interface rcsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_command;

  modport source (output valid, output data_byte, output start_of_command, input ready);
  modport sink (input valid, input data_byte, input start_of_command, output ready);
endinterface

interface rcsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] part_index;
  logic       part_end;
  logic       command_end;
  logic [2:0] status;

  modport source (output valid, output out_byte, output part_index, output part_end,
                  output command_end, output status, input ready);
  modport sink (input valid, input out_byte, input part_index, input part_end,
                input command_end, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/rcsp_front.sv =====
// Front end: takes request bytes, tracks framing and classifies each byte.
`default_nettype none

module rcsp_front #(
  parameter int unsigned MAX_PARTS       = rcsp_pkg::MAX_PARTS_DEF,
  parameter int unsigned MAX_PART_LENGTH = rcsp_pkg::MAX_PART_LENGTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  rcsp_in_if.sink                cmd_in,
  input  wire logic              space,
  output logic                   push,
  output rcsp_pkg::rcsp_rec_t    rec
);
  import rcsp_pkg::*;

  localparam int unsigned CAP_TOP = ((MAX_PARTS > MAX_PART_LENGTH) ? MAX_PARTS
                                     : MAX_PART_LENGTH) + 1;
  localparam int unsigned AW  = $clog2(CAP_TOP + 1);
  localparam int unsigned PW  = $clog2(MAX_PARTS + 1);
  localparam int unsigned BW  = $clog2(MAX_PART_LENGTH + 1);
  localparam int unsigned MW  = AW + 4;

  typedef enum logic [2:0] {
    PH_IDLE, PH_COUNT, PH_MARK, PH_LEN, PH_DATA, PH_TRAIL
  } phase_t;

  phase_t          phase, phase_next;
  logic [AW-1:0]   accum, accum_next;
  logic            num_done, num_done_next;
  logic            num_neg, num_neg_next;
  logic            num_fresh, num_fresh_next;
  logic [PW-1:0]   parts_left, parts_left_next;
  logic [PW-1:0]   part_number, part_number_next;
  logic [BW-1:0]   bytes_left, bytes_left_next;
  logic [1:0]      trailer_left, trailer_left_next;

  logic            accept;
  logic [7:0]      b;
  logic            is_digit;
  logic [AW-1:0]   cap;
  logic [MW-1:0]   prod;
  logic [AW-1:0]   fed;
  logic [PW+3:0]   part_wide;
  logic [3:0]      part_lo;
  logic            last;
  logic [PW-1:0]   parts_dec;

  assign cmd_in.ready = space;
  assign accept       = cmd_in.valid && space;
  assign b            = cmd_in.data_byte;
  assign is_digit     = (b >= CHR_ZERO) && (b <= CHR_NINE);
  assign cap          = (phase == PH_COUNT) ? AW'(MAX_PARTS + 1) : AW'(MAX_PART_LENGTH + 1);
  assign prod         = ({4'b0, accum} << 3) + ({4'b0, accum} << 1) + MW'(b[3:0]);
  assign fed          = (prod > MW'(cap)) ? cap : prod[AW-1:0];
  assign part_wide    = {4'b0, part_number};
  assign part_lo      = part_wide[3:0];
  assign last         = (bytes_left <= BW'(1));
  assign parts_dec    = (parts_left != '0) ? parts_left - PW'(1) : parts_left;

  always_comb begin
    phase_next        = phase;
    accum_next        = accum;
    num_done_next     = num_done;
    num_neg_next      = num_neg;
    num_fresh_next    = num_fresh;
    parts_left_next   = parts_left;
    part_number_next  = part_number;
    bytes_left_next   = bytes_left;
    trailer_left_next = trailer_left;
    push              = 1'b0;
    rec.status        = ST_DATA;
    rec.data          = 8'd0;
    rec.part          = part_lo;
    rec.part_end      = 1'b0;
    rec.command_end   = 1'b1;
    rec.fold          = 1'b0;

    if (accept) begin
      if (cmd_in.start_of_command) begin
        phase_next        = PH_COUNT;
        accum_next        = '0;
        num_done_next     = 1'b0;
        num_neg_next      = 1'b0;
        num_fresh_next    = 1'b1;
        parts_left_next   = '0;
        part_number_next  = '0;
        bytes_left_next   = '0;
        trailer_left_next = '0;
      end else begin
        case (phase)
          PH_COUNT, PH_LEN: begin
            if (b != CHR_NEWLINE) begin
              if (!num_done) begin
                num_fresh_next = 1'b0;
                if (num_fresh && (b == CHR_MINUS || b == CHR_PLUS)) begin
                  num_neg_next = (b == CHR_MINUS);
                end else if (is_digit) begin
                  accum_next = fed;
                end else begin
                  num_done_next = 1'b1;
                end
              end
            end else if (phase == PH_COUNT) begin
              if (num_neg || accum == '0) begin
                phase_next  = PH_IDLE;
                push        = 1'b1;
                rec.status  = ST_EMPTY;
                rec.part    = 4'd0;
              end else if (accum > AW'(MAX_PARTS)) begin
                phase_next  = PH_IDLE;
                push        = 1'b1;
                rec.status  = ST_TOO_MANY;
              end else begin
                parts_left_next  = accum[PW-1:0];
                part_number_next = '0;
                phase_next       = PH_MARK;
              end
            end else begin
              if (num_neg || accum == '0 || accum > AW'(MAX_PART_LENGTH)) begin
                phase_next = PH_IDLE;
                push       = 1'b1;
                rec.status = ST_BAD_LENGTH;
              end else begin
                bytes_left_next = accum[BW-1:0];
                phase_next      = PH_DATA;
              end
            end
          end
          PH_MARK: begin
            if (b != CHR_DOLLAR) begin
              phase_next = PH_IDLE;
              push       = 1'b1;
              rec.status = ST_BAD_MARKER;
            end else begin
              accum_next     = '0;
              num_done_next  = 1'b0;
              num_neg_next   = 1'b0;
              num_fresh_next = 1'b1;
              phase_next     = PH_LEN;
            end
          end
          PH_DATA: begin
            push            = 1'b1;
            rec.data        = b;
            rec.fold        = (part_number == '0);
            rec.part_end    = last;
            rec.command_end = last && (parts_left <= PW'(1));
            if (last) begin
              bytes_left_next   = '0;
              parts_left_next   = parts_dec;
              part_number_next  = part_number + PW'(1);
              trailer_left_next = TRAILER_LEN;
              phase_next        = PH_TRAIL;
            end else begin
              bytes_left_next = bytes_left - BW'(1);
            end
          end
          PH_TRAIL: begin
            if (trailer_left <= 2'd1) begin
              trailer_left_next = '0;
              phase_next        = (parts_left == '0) ? PH_IDLE : PH_MARK;
            end else begin
              trailer_left_next = trailer_left - 2'd1;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      accum        <= '0;
      num_done     <= 1'b0;
      num_neg      <= 1'b0;
      num_fresh    <= 1'b1;
      parts_left   <= '0;
      part_number  <= '0;
      bytes_left   <= '0;
      trailer_left <= '0;
    end else begin
      phase        <= phase_next;
      accum        <= accum_next;
      num_done     <= num_done_next;
      num_neg      <= num_neg_next;
      num_fresh    <= num_fresh_next;
      parts_left   <= parts_left_next;
      part_number  <= part_number_next;
      bytes_left   <= bytes_left_next;
      trailer_left <= trailer_left_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rcsp_queue.sv =====
// Short result queue between the parser front end and the output stage.
`default_nettype none

module rcsp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  rcsp_pkg::rcsp_rec_t       wr_rec,
  output logic                      space,
  input  wire logic                 pop,
  output rcsp_pkg::rcsp_rec_t       rd_rec,
  output logic                      has_item
);
  import rcsp_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  rcsp_rec_t      store [QUEUE_DEPTH];
  logic [IW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign space    = (count < CW'(QUEUE_DEPTH));
  assign has_item = (count != '0);
  assign rd_rec   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + IW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + IW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rcsp_back.sv =====
// Back end: folds command-word case and holds the result in the output register.
`default_nettype none

module rcsp_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 has_item,
  input  rcsp_pkg::rcsp_rec_t       rec,
  output logic                      pop,
  rcsp_out_if.source                cmd_out
);
  import rcsp_pkg::*;

  logic [7:0] folded;

  assign pop    = has_item && (!cmd_out.valid || cmd_out.ready);
  assign folded = (rec.fold && rec.data >= CHR_LOW_A && rec.data <= CHR_LOW_Z)
                  ? rec.data - CASE_OFFSET : rec.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_out.valid <= 1'b0;
    end else if (pop) begin
      cmd_out.valid <= 1'b1;
    end else if (cmd_out.ready) begin
      cmd_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_out.out_byte    <= folded;
      cmd_out.part_index  <= rec.part;
      cmd_out.part_end    <= rec.part_end;
      cmd_out.command_end <= rec.command_end;
      cmd_out.status      <= rec.status;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/resp_command_stream_parser.sv =====
// Throughput: one request byte per clock cycle sustained while the result queue has a free slot.
// Path: a result enters the queue at the edge that accepts its byte and moves from the queue
// into the output register, which offers it on cmd_out, once that register is free.
// Bytes that cause no result (header, lengths, markers, trailers) leave nothing behind.
// Reset (rst, synchronous, active high) returns the parser to idle and empties the
// queue and the output register; bytes are then ignored until a start of command.
`default_nettype none

module resp_command_stream_parser #(
  parameter int unsigned MAX_PARTS       = rcsp_pkg::MAX_PARTS_DEF,
  parameter int unsigned MAX_PART_LENGTH = rcsp_pkg::MAX_PART_LENGTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  rcsp_in_if.sink     cmd_in,
  rcsp_out_if.source  cmd_out
);
  import rcsp_pkg::*;

  // The front end classifies every accepted item in the cycle it arrives and
  // writes any result it produces into the queue at that same edge. It takes
  // items only while the queue has a free slot, so a stalled consumer holds
  // the input back only once the queue has filled.
  logic       push;
  logic       pop;
  logic       space;
  logic       has_item;
  rcsp_rec_t  push_rec;
  rcsp_rec_t  pop_rec;

  rcsp_front #(
    .MAX_PARTS       (MAX_PARTS),
    .MAX_PART_LENGTH (MAX_PART_LENGTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd_in (cmd_in),
    .space  (space),
    .push   (push),
    .rec    (push_rec)
  );

  // The queue decouples parsing from delivery: results wait here while the
  // output register is held by the consumer.
  rcsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_rec   (push_rec),
    .space    (space),
    .pop      (pop),
    .rd_rec   (pop_rec),
    .has_item (has_item)
  );

  // The back end upper-cases bytes of the command word and loads the output register
  // whenever a result waits and the register is empty or being emptied in the same cycle.
  rcsp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .has_item (has_item),
    .rec      (pop_rec),
    .pop      (pop),
    .cmd_out  (cmd_out)
  );

  // A result is never written into a full queue.
  a_no_push_when_full : assert property (@(posedge clk) disable iff (rst)
    push |-> space)
    else $error("result written into a full queue");

  // The output stage never takes a result from an empty queue.
  a_no_pop_when_empty : assert property (@(posedge clk) disable iff (rst)
    pop |-> has_item)
    else $error("result taken from an empty queue");

  // A start of command is always silent: it only restarts the framing.
  a_start_is_silent : assert property (@(posedge clk) disable iff (rst)
    (cmd_in.valid && cmd_in.ready && cmd_in.start_of_command) |-> !push)
    else $error("start of command produced a result");

  // Whatever enters the queue is popped toward the output register in the cycle after
  // its push when the queue was empty and the output free.
  a_direct_path : assert property (@(posedge clk) disable iff (rst)
    (push && !has_item && (!cmd_out.valid || cmd_out.ready)) |=> (pop && has_item))
    else $error("result stuck in an otherwise idle queue");

endmodule

`default_nettype wire
